FILE: rtl/core/sps_pkg.sv
// sps_pkg: types and constants of the servo position selector.
// No dependencies; used by the interfaces, sps_step, sps_rbuf and the top level.
package sps_pkg;

  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned NUM_ANGLES  = 5;
  localparam int unsigned MASK_W      = 5;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
  localparam logic [ANGLE_W-1:0] SMOOTH_LIMIT = 8'd10;

  localparam logic [ANGLE_W-1:0] ANGLE_POS0_RST = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_POS1_RST = 8'd45;
  localparam logic [ANGLE_W-1:0] ANGLE_POS2_RST = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_POS3_RST = 8'd135;
  localparam logic [ANGLE_W-1:0] ANGLE_POS4_RST = 8'd180;
  localparam logic [MASK_W-1:0]  MASK_RST       = 5'd31;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT = 3'd0,
    ACT_SET  = 3'd1,
    ACT_NEXT = 3'd2,
    ACT_RAW  = 3'd3,
    ACT_TICK = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_BUSY      = 3'd3,
    ST_NO_OTHER  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_POS0 = 3'd0,
    CFG_ANGLE_POS1 = 3'd1,
    CFG_ANGLE_POS2 = 3'd2,
    CFG_ANGLE_POS3 = 3'd3,
    CFG_ANGLE_POS4 = 3'd4,
    CFG_ENABLED    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position_index;
    logic                smooth;
    logic [ANGLE_W-1:0]  raw_angle;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  servo_angle;
    logic [POS_W-1:0]    position_now;
    logic                sweeping;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [ANGLE_W-1:0]  angle;
    logic [ANGLE_W-1:0]  target;
    logic                sweep;
  } state_t;

  typedef struct packed {
    logic [NUM_ANGLES-1:0][ANGLE_W-1:0] angle;
    logic [MASK_W-1:0]                  mask;
  } cfg_t;

endpackage

FILE: rtl/core/sps_if.sv
// sps_in_if / sps_out_if: valid/ready channels of the servo position selector.
// Depends on sps_pkg for the payload types.
interface sps_in_if;
  logic         valid;
  logic         ready;
  sps_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sps_out_if;
  logic          valid;
  logic          ready;
  sps_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/sps_step.sv
// sps_step: next state and result of one command beat, purely combinational.
// Depends on sps_pkg.
module sps_step #(
  parameter int unsigned NUM_POSITIONS = 5
) (
  input  sps_pkg::state_t st_i,
  input  sps_pkg::cfg_t   cfg_i,
  input  sps_pkg::in_t    item_i,
  output sps_pkg::state_t st_o,
  output sps_pkg::out_t   res_o
);

  localparam int unsigned SumW = $clog2(2 * NUM_POSITIONS);

  logic [SumW-1:0]               sum;
  logic [sps_pkg::POS_W-1:0]     cand;
  logic [sps_pkg::POS_W-1:0]     found;
  logic [(1 << sps_pkg::POS_W)-1:0] en_all;
  logic [sps_pkg::POS_W-1:0]     sel_idx;
  logic [sps_pkg::ANGLE_W-1:0]   raw_sel;
  logic [sps_pkg::ANGLE_W-1:0]   tgt;
  logic [sps_pkg::ANGLE_W-1:0]   init_ang;
  logic [sps_pkg::ANGLE_W-1:0]   diff;
  logic [sps_pkg::ANGLE_W-1:0]   tick_ang;
  logic                          idx_ok;
  logic                          busy_cmd;
  sps_pkg::state_t               st_n;
  sps_pkg::status_e              status;

  function automatic logic [sps_pkg::ANGLE_W-1:0] clamp_angle(
    input logic [sps_pkg::ANGLE_W-1:0] a
  );
    return (a > sps_pkg::ANGLE_MAX) ? sps_pkg::ANGLE_MAX : a;
  endfunction

  // round-robin search from the slot after the current position
  always_comb begin
    en_all = {{((1 << sps_pkg::POS_W) - sps_pkg::MASK_W){1'b0}}, cfg_i.mask};
    found  = st_i.position;
    sum    = '0;
    cand   = '0;
    for (int i = NUM_POSITIONS - 1; i >= 0; i--) begin
      sum = SumW'(st_i.position) + SumW'(i + 1);
      if (sum >= SumW'(NUM_POSITIONS)) begin
        sum = sum - SumW'(NUM_POSITIONS);
      end
      cand = sps_pkg::POS_W'(sum);
      if (en_all[cand]) begin
        found = cand;
      end
    end
  end

  always_comb begin
    sel_idx = (item_i.action == sps_pkg::ACT_NEXT) ? found : item_i.position_index;
    raw_sel = sps_pkg::ANGLE_MAX;
    for (int k = 0; k < sps_pkg::NUM_ANGLES; k++) begin
      if (sel_idx == sps_pkg::POS_W'(k)) begin
        raw_sel = cfg_i.angle[k];
      end
    end
    tgt      = clamp_angle(raw_sel);
    init_ang = clamp_angle(cfg_i.angle[0]);
    diff     = (tgt > st_i.angle) ? (tgt - st_i.angle) : (st_i.angle - tgt);
    idx_ok   = {1'b0, sel_idx} < (sps_pkg::POS_W + 1)'(NUM_POSITIONS);
    if (st_i.angle < st_i.target) begin
      tick_ang = st_i.angle + 8'd1;
    end else if (st_i.angle > st_i.target) begin
      tick_ang = st_i.angle - 8'd1;
    end else begin
      tick_ang = st_i.angle;
    end
    busy_cmd = st_i.sweep && (item_i.action == sps_pkg::ACT_INIT ||
                              item_i.action == sps_pkg::ACT_SET  ||
                              item_i.action == sps_pkg::ACT_NEXT ||
                              item_i.action == sps_pkg::ACT_RAW);
  end

  always_comb begin
    st_n   = st_i;
    status = sps_pkg::ST_OK;
    if (item_i.action == sps_pkg::ACT_TICK) begin
      if (st_i.sweep) begin
        st_n.angle = tick_ang;
        if (tick_ang == st_i.target) begin
          st_n.sweep = 1'b0;
        end
      end
    end else if (busy_cmd) begin
      status = sps_pkg::ST_BUSY;
    end else begin
      case (item_i.action)
        sps_pkg::ACT_INIT: begin
          st_n.position = '0;
          st_n.angle    = init_ang;
          st_n.ready    = 1'b1;
        end
        sps_pkg::ACT_SET, sps_pkg::ACT_NEXT: begin
          if (item_i.action == sps_pkg::ACT_NEXT && found == st_i.position) begin
            status = sps_pkg::ST_NO_OTHER;
          end else if (!st_i.ready) begin
            status = sps_pkg::ST_NOT_READY;
          end else if (!idx_ok) begin
            status = sps_pkg::ST_BAD_INDEX;
          end else begin
            st_n.position = sel_idx;
            if ((item_i.smooth || item_i.action == sps_pkg::ACT_NEXT) &&
                diff > sps_pkg::SMOOTH_LIMIT) begin
              st_n.target = tgt;
              st_n.sweep  = 1'b1;
            end else begin
              st_n.angle = tgt;
            end
          end
        end
        sps_pkg::ACT_RAW: begin
          if (!st_i.ready) begin
            status = sps_pkg::ST_NOT_READY;
          end else begin
            st_n.angle = clamp_angle(item_i.raw_angle);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign st_o               = st_n;
  assign res_o.servo_angle  = st_n.angle;
  assign res_o.position_now = st_n.position;
  assign res_o.sweeping     = st_n.sweep;
  assign res_o.status       = status;

endmodule

FILE: rtl/core/sps_rbuf.sv
// sps_rbuf: two-entry result buffer between the command logic and the result channel.
// Depends on sps_pkg and sps_out_if.
module sps_rbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sps_pkg::out_t     push_data_i,
  output logic              full_o,
  sps_out_if.source         out_o
);

  sps_pkg::out_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = mem_q[rd_ptr_q];
  assign full_o      = (cnt_q == 2'd2);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/servo_position_selector.sv
// servo_position_selector: top level of the outlet servo position selector.
// Depends on sps_pkg, sps_if, sps_step and sps_rbuf.
//
//   channel  dir  beat payload                                   handshake
//   in_i     in   action, position_index, smooth, raw_angle      valid/ready
//   out_o    out  servo_angle, position_now, sweeping, status    valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                         cfg_we_i
//
// One command beat per cycle while in_i.ready is high; its result beat is registered.
// The state update is one combinational pass between the state and result registers.
// A two-entry result buffer lets in_i keep accepting while out_o stalls for one beat;
// in_i.ready drops only when both entries hold undelivered results.
// Reset: not ready, position 0, angle 0, no sweep, config registers at their defaults.
module servo_position_selector #(
  parameter int unsigned NUM_POSITIONS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  sps_in_if.sink                            in_i,
  sps_out_if.source                         out_o
);

  sps_pkg::state_t st_q, st_d;
  sps_pkg::cfg_t   cfg_q;
  sps_pkg::out_t   res;
  logic            in_fire;
  logic            buf_full;

  assign in_i.ready = !buf_full;
  assign in_fire    = in_i.valid && in_i.ready;

  sps_step #(
    .NUM_POSITIONS(NUM_POSITIONS)
  ) u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (in_i.data),
    .st_o   (st_d),
    .res_o  (res)
  );

  sps_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle[0] <= sps_pkg::ANGLE_POS0_RST;
      cfg_q.angle[1] <= sps_pkg::ANGLE_POS1_RST;
      cfg_q.angle[2] <= sps_pkg::ANGLE_POS2_RST;
      cfg_q.angle[3] <= sps_pkg::ANGLE_POS3_RST;
      cfg_q.angle[4] <= sps_pkg::ANGLE_POS4_RST;
      cfg_q.mask     <= sps_pkg::MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::CFG_ANGLE_POS0: cfg_q.angle[0] <= cfg_wdata_i;
        sps_pkg::CFG_ANGLE_POS1: cfg_q.angle[1] <= cfg_wdata_i;
        sps_pkg::CFG_ANGLE_POS2: cfg_q.angle[2] <= cfg_wdata_i;
        sps_pkg::CFG_ANGLE_POS3: cfg_q.angle[3] <= cfg_wdata_i;
        sps_pkg::CFG_ANGLE_POS4: cfg_q.angle[4] <= cfg_wdata_i;
        sps_pkg::CFG_ENABLED:    cfg_q.mask     <= cfg_wdata_i[sps_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a sweep always has somewhere left to go
  a_sweep_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.sweep |-> st_q.angle != st_q.target)
    else $error("sweep active with angle at target");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, st_q.position} < (sps_pkg::POS_W + 1)'(NUM_POSITIONS))
    else $error("position out of range");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.angle <= sps_pkg::ANGLE_MAX && st_q.target <= sps_pkg::ANGLE_MAX)
    else $error("angle above limit");

  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && st_q.sweep && in_i.data.action != sps_pkg::ACT_TICK
      |=> $stable(st_q.angle) && $stable(st_q.position) && st_q.sweep)
    else $error("command changed state during sweep");

endmodule

FILE: test/servo_result_checker.sv
`timescale 1ns / 100ps
// servo_result_checker: watches the command, result and config ports of the servo
// position selector, predicts each result beat and compares it field by field.
// Depends on sps_pkg and the sps_in_if / sps_out_if interfaces.
module servo_result_checker import sps_pkg::*; #(
  parameter int unsigned NUM_POSITIONS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sps_in_if                     cmd_i,
  sps_out_if                    res_i,
  output int unsigned           mismatches_o,
  output int unsigned           outstanding_o
);

  logic [ANGLE_W-1:0] angle_tbl [NUM_ANGLES];
  logic [MASK_W-1:0]  enable_mask;

  logic               ready_q;
  logic [POS_W-1:0]   pos_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [ANGLE_W-1:0] target_q;
  logic               sweep_q;

  out_t               pending_results [$];

  function automatic logic [ANGLE_W-1:0] outlet_angle(int unsigned idx);
    logic [ANGLE_W-1:0] a;
    a = ANGLE_MAX;
    if (idx < NUM_ANGLES) begin
      a = angle_tbl[idx];
    end
    if (a > ANGLE_MAX) begin
      a = ANGLE_MAX;
    end
    return a;
  endfunction

  function automatic status_e move_to(int unsigned idx, logic smooth);
    logic [ANGLE_W-1:0] goal;
    logic [ANGLE_W-1:0] span;
    if (!ready_q) begin
      return ST_NOT_READY;
    end
    if (idx >= NUM_POSITIONS) begin
      return ST_BAD_INDEX;
    end
    goal  = outlet_angle(idx);
    span  = (goal > angle_q) ? goal - angle_q : angle_q - goal;
    pos_q = POS_W'(idx);
    if (smooth && span > SMOOTH_LIMIT) begin
      target_q = goal;
      sweep_q  = 1'b1;
    end else begin
      angle_q = goal;
    end
    return ST_OK;
  endfunction

  function automatic out_t advance_servo(in_t cmd);
    status_e     st;
    int unsigned hop;
    int unsigned cand;
    int unsigned found;
    logic        hit;
    out_t        r;
    st = ST_OK;
    if (cmd.action == ACT_TICK) begin
      if (sweep_q) begin
        if (angle_q < target_q) begin
          angle_q = angle_q + 1'b1;
        end else if (angle_q > target_q) begin
          angle_q = angle_q - 1'b1;
        end
        if (angle_q == target_q) begin
          sweep_q = 1'b0;
        end
      end
    end else if (cmd.action <= ACT_RAW && sweep_q) begin
      st = ST_BUSY;
    end else if (cmd.action == ACT_INIT) begin
      pos_q   = '0;
      angle_q = outlet_angle(0);
      ready_q = 1'b1;
    end else if (cmd.action == ACT_SET) begin
      st = move_to(cmd.position_index, cmd.smooth);
    end else if (cmd.action == ACT_NEXT) begin
      // round-robin from the slot after the current one, wrapping back to it
      found = pos_q;
      hit   = 1'b0;
      for (hop = 1; hop <= NUM_POSITIONS; hop++) begin
        cand = (pos_q + hop) % NUM_POSITIONS;
        if (!hit && cand < MASK_W && enable_mask[cand]) begin
          found = cand;
          hit   = 1'b1;
        end
      end
      if (found == pos_q) begin
        st = ST_NO_OTHER;
      end else begin
        st = move_to(found, 1'b1);
      end
    end else if (cmd.action == ACT_RAW) begin
      if (!ready_q) begin
        st = ST_NOT_READY;
      end else begin
        angle_q = (cmd.raw_angle > ANGLE_MAX) ? ANGLE_MAX : cmd.raw_angle;
      end
    end
    r.servo_angle  = angle_q;
    r.position_now = pos_q;
    r.sweeping     = sweep_q;
    r.status       = st;
    return r;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      angle_tbl[0]  = ANGLE_POS0_RST;
      angle_tbl[1]  = ANGLE_POS1_RST;
      angle_tbl[2]  = ANGLE_POS2_RST;
      angle_tbl[3]  = ANGLE_POS3_RST;
      angle_tbl[4]  = ANGLE_POS4_RST;
      enable_mask   = MASK_RST;
      ready_q       = 1'b0;
      pos_q         = '0;
      angle_q       = ANGLE_POS0_RST;
      target_q      = '0;
      sweep_q       = 1'b0;
      pending_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < NUM_ANGLES) begin
          angle_tbl[cfg_idx_i] = cfg_wdata_i;
        end else if (cfg_idx_i == CFG_ENABLED) begin
          enable_mask = cfg_wdata_i[MASK_W-1:0];
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (pending_results.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, res_i.data);
        end else begin
          want = pending_results.pop_front();
          compare_field("servo_angle", want.servo_angle, res_i.data.servo_angle);
          compare_field("position_now", want.position_now, res_i.data.position_now);
          compare_field("sweeping", want.sweeping, res_i.data.sweeping);
          compare_field("status", want.status, res_i.data.status);
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        pending_results.push_back(advance_servo(cmd_i.data));
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

FILE: test/tb_servo_position_selector.sv
`timescale 1ns / 100ps
// tb_servo_position_selector: drives commands, config writes and result stalls
// into servo_position_selector; servo_result_checker predicts and compares beats.
// Depends on sps_pkg, sps_if, the RTL and servo_result_checker.
module tb_servo_position_selector;
  import sps_pkg::*;

  localparam int unsigned POSITIONS   = 5;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [ACTION_W-1:0]  ACT_UNKNOWN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  steady = 1'b0;
  int unsigned           mismatches;
  int unsigned           outstanding;

  sps_in_if  in_ch ();
  sps_out_if out_ch ();

  servo_position_selector #(
    .NUM_POSITIONS(POSITIONS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  servo_result_checker #(
    .NUM_POSITIONS(POSITIONS)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (in_ch),
    .res_i         (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99, 0) >= 9);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_servo_position_selector: FAIL");
    $finish;
  end

  // one command beat; called at a falling edge, returns at the falling edge after accept
  task automatic issue_cmd(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] idx,
                           input logic smooth, input logic [ANGLE_W-1:0] raw);
    int unsigned gap;
    in_t         cmd;
    gap = 0;
    while (!steady && $urandom_range(99, 0) < 9) begin
      gap++;
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd.action         = act;
    cmd.position_index = idx;
    cmd.smooth         = smooth;
    cmd.raw_angle      = raw;
    in_ch.valid <= 1'b1;
    in_ch.data  <= cmd;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [ANGLE_W-1:0] a0, a1, a2, a3, a4,
                               input logic [MASK_W-1:0] mask);
    logic [ANGLE_W-1:0] vals [NUM_ANGLES];
    int unsigned        i;
    vals = '{a0, a1, a2, a3, a4};
    for (i = 0; i < NUM_ANGLES; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(CFG_ANGLE_POS0 + i);
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
    end
    // upper data bits of the mask write are don't-care
    cfg_idx_i   <= CFG_ENABLED;
    cfg_wdata_i <= {3'($urandom), mask};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= 8'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned         phase;
    int unsigned         sent;
    int unsigned         pick;
    int unsigned         burst;
    int unsigned         k;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    idx;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: only position 1 enabled, angle 3 above range
    load_settings(8'd5, 8'd16, 8'd15, 8'd255, 8'd180, 5'b00010);
    issue_cmd(ACT_TICK, 3'd0, 1'b0, 8'd0);
    issue_cmd(ACT_SET, 3'd1, 1'b1, 8'd0);
    issue_cmd(ACT_RAW, 3'd0, 1'b0, 8'd200);
    issue_cmd(ACT_NEXT, 3'd0, 1'b1, 8'd0);
    issue_cmd(ACT_UNKNOWN, 3'd2, 1'b1, 8'd77);
    issue_cmd(ACT_INIT, 3'd7, 1'b1, 8'd255);
    issue_cmd(ACT_SET, 3'd5, 1'b0, 8'd0);
    issue_cmd(ACT_RAW, 3'd0, 1'b0, 8'd255);
    issue_cmd(ACT_SET, 3'd3, 1'b1, 8'd0);
    issue_cmd(ACT_RAW, 3'd0, 1'b0, 8'd26);
    // ten degrees exactly: jumps even with smooth set
    issue_cmd(ACT_SET, 3'd1, 1'b1, 8'd0);
    issue_cmd(ACT_INIT, 3'd0, 1'b0, 8'd0);
    // eleven degrees: sweep starts, everything but tick is busy
    issue_cmd(ACT_NEXT, 3'd0, 1'b0, 8'd0);
    issue_cmd(ACT_SET, 3'd0, 1'b0, 8'd0);
    issue_cmd(ACT_INIT, 3'd0, 1'b0, 8'd0);
    issue_cmd(ACT_RAW, 3'd0, 1'b0, 8'd90);
    issue_cmd(ACT_NEXT, 3'd0, 1'b0, 8'd0);
    repeat (11) issue_cmd(ACT_TICK, 3'd0, 1'b0, 8'd0);
    issue_cmd(ACT_NEXT, 3'd0, 1'b1, 8'd0);

    for (phase = 0; phase < 5; phase++) begin
      drain();
      steady = (phase == 0);
      case (phase)
        0: begin
          load_settings(ANGLE_POS0_RST, ANGLE_POS1_RST, ANGLE_POS2_RST, ANGLE_POS3_RST,
                        ANGLE_POS4_RST, MASK_RST);
        end
        1: begin
          load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 5'($urandom));
        end
        2: begin
          load_settings(8'd255, 8'd0, 8'd181, 8'd180, 8'd0, 5'b10001);
        end
        3: begin
          load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), MASK_W'(1 << $urandom_range(MASK_W-1, 0)));
        end
        default: begin
          load_settings(8'd180, 8'd180, 8'd0, 8'd0, 8'd90, 5'b00000);
        end
      endcase

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if ($urandom_range(5, 0) == 0) begin
          idx = POS_W'($urandom);
        end else begin
          idx = POS_W'($urandom_range(POSITIONS-1, 0));
        end
        if (pick < 35) begin
          burst = $urandom_range(40, 1);
          for (k = 0; k < burst; k++) begin
            issue_cmd(ACT_TICK, POS_W'($urandom), 1'($urandom), 8'($urandom));
          end
          sent += burst;
        end else begin
          if (pick < 60) begin
            act = ACT_SET;
          end else if (pick < 75) begin
            act = ACT_NEXT;
          end else if (pick < 85) begin
            act = ACT_RAW;
          end else if (pick < 92) begin
            act = ACT_INIT;
          end else begin
            act = ACTION_W'($urandom);
          end
          issue_cmd(act, idx, $urandom_range(3, 0) != 0, 8'($urandom));
          if (act <= ACT_TICK) begin
            sent++;
          end
        end
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("tb_servo_position_selector: PASS");
    end else begin
      $display("tb_servo_position_selector: FAIL");
    end
    $finish;
  end

endmodule
